/* hw/rtl/crfg_pkg.sv */
// Shared types and constants for the clip resampler with gain and fades.
package crfg_pkg;

    localparam int MAX_OUT_DEF     = 16;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 56;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE_RATIO   = 3'd0,
        REG_START_OFFSET = 3'd1,
        REG_CLIP_LENGTH  = 3'd2,
        REG_GAIN         = 3'd3,
        REG_FADE_IN      = 3'd4,
        REG_FADE_OUT     = 3'd5,
        REG_XFADE_IN     = 3'd6,
        REG_XFADE_OUT    = 3'd7
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FSEL,
        ST_DIV,
        ST_SQRT,
        ST_FMUL,
        ST_FWB,
        ST_GMUL,
        ST_GWB,
        ST_SDIF,
        ST_SVAL,
        ST_SOUT,
        ST_SSAT,
        ST_EMIT,
        ST_SKMUL,
        ST_SKADD,
        ST_END
    } crfg_state_t;

endpackage

/* hw/rtl/clip_resample_fade_gain.sv */
// Resampling clip player: linear interpolation, gain, linear and square-root fades.
//
// Source frames enter one per item on s_; each frame yields zero to MAX_OUTPUTS_PER_FRAME
// clip samples on m_, the last of them flagged on m_tlast. The block takes no new frame
// until all work for the current one is done. Each output sample is computed by one
// shared 33x33 multiplier, a restoring divider and a square-root stepper under a
// sequencer, which runs a division for each active fade (with a square root for the
// cross-fades) and waits while the output is held off. When the output cap is hit the
// remaining samples up to the frame are skipped with one 57-step division. Writing
// start_offset restarts the run; configuration is to be written by the user only while
// the block is idle, which the block itself does not enforce.
module clip_resample_fade_gain #(
    parameter int MAX_OUTPUTS_PER_FRAME = crfg_pkg::MAX_OUT_DEF,
    parameter int SAMPLE_BITS           = crfg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [crfg_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  logic [crfg_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // src_left, src_right
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    input  logic                                   s_tlast,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // out_left, out_right, out_position
    output logic [((2*SAMPLE_BITS+32+7)/8)*8-1:0]  m_tdata,
    output logic                                   m_tlast
);
    import crfg_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int ODW = ((2*SB+32+7)/8)*8;
    localparam int MW  = (SB + 2 > 33) ? SB + 2 : 33;
    localparam int PW  = 2*MW;
    localparam int NW  = $clog2(MAX_OUTPUTS_PER_FRAME + 1);
    localparam logic signed [PW-1:0] SAT_HI  = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_LO  = ~SAT_HI;
    localparam logic signed [PW-1:0] ROUND_C = {{(PW-28){1'b0}}, 1'b1, 27'b0};

    crfg_state_t state_reg, state_next;

    logic [20:0] rr_reg;
    logic [31:0] clen_reg, fin_reg, fout_reg, xin_reg, xout_reg;
    logic [15:0] gain_reg;

    logic [55:0] pos_reg;
    logic [31:0] cc_reg;
    logic [39:0] fi_reg;
    logic signed [SB-1:0] prev_l_reg, prev_r_reg;
    logic done_reg;

    logic signed [SB-1:0] cur_l_reg, cur_r_reg, a_l_reg, a_r_reg, b_l_reg, b_r_reg;
    logic cur_last_reg, span_b_reg, ch_reg, dv_skip_reg;
    logic [56:0] bound_reg;
    logic [NW-1:0] n_reg;
    logic [1:0] k_reg;
    logic [24:0] f_reg;
    logic [23:0] fac_reg;
    logic [29:0] gf_reg;
    logic signed [SB+1:0] v_reg;
    logic signed [SB-1:0] res_l_reg, res_r_reg;
    logic [31:0] dv_rem_reg, dv_den_reg;
    logic [56:0] dv_num_reg, dv_q_reg;
    logic [5:0] it_reg;
    logic [47:0] sq_x_reg, sq_r_reg, sq_bit_reg;
    logic signed [PW-1:0] prod_reg;

    logic pend_valid_reg;
    logic signed [SB-1:0] pend_l_reg, pend_r_reg;
    logic [31:0] pend_pos_reg;
    logic m_valid_reg, m_last_reg;
    logic signed [SB-1:0] m_l_reg, m_r_reg;
    logic [31:0] m_pos_reg;

    logic acc, out_free, run_ok, more, emit_go, end_go, it_zero;
    logic [20:0] r_eff;
    logic [31:0] rest, left, fade_num, fade_len, skip_cnt;
    logic fade_act;
    logic [56:0] pos_x, pos_inc, pos_skip, bound_a, bound_b, skip_d;
    logic [32:0] dv_t, dv_sub;
    logic dv_ge;
    logic [47:0] sq_rb;
    logic signed [SB:0] diff;
    logic signed [SB-1:0] a_sel, b_sel;
    logic signed [SB+1:0] v_val;
    logic signed [PW-1:0] rnd, shr;
    logic signed [SB-1:0] sat_val;
    logic signed [MW-1:0] mul_a, mul_b;

    assign r_eff    = (rr_reg < 21'd4096) ? 21'd4096 : rr_reg;
    assign pos_x    = {1'b0, pos_reg};
    assign pos_inc  = pos_x + {36'b0, r_eff};
    assign pos_skip = pos_x + prod_reg[56:0];
    assign bound_a  = {1'b0, fi_reg, 16'b0};
    assign bound_b  = {({1'b0, fi_reg} + 41'd1), 16'b0};
    assign skip_d   = bound_reg - pos_x + {36'b0, r_eff} - 57'd1;
    assign rest     = clen_reg - cc_reg;
    assign left     = clen_reg - cc_reg;
    assign skip_cnt = (dv_q_reg > {25'b0, left}) ? left : dv_q_reg[31:0];
    assign more     = (cc_reg < clen_reg) && (pos_x < bound_reg);
    assign run_ok   = more && (n_reg < NW'(MAX_OUTPUTS_PER_FRAME));
    assign it_zero  = (it_reg == 6'd0);

    always_comb begin
        unique case (k_reg)
            2'd0: begin fade_num = cc_reg; fade_len = fin_reg;  end
            2'd1: begin fade_num = rest;   fade_len = fout_reg; end
            2'd2: begin fade_num = cc_reg; fade_len = xin_reg;  end
            default: begin fade_num = rest; fade_len = xout_reg; end
        endcase
        fade_act = (fade_num < fade_len);
    end

    assign dv_t   = {dv_rem_reg, dv_num_reg[56]};
    assign dv_ge  = (dv_t >= {1'b0, dv_den_reg});
    assign dv_sub = dv_t - {1'b0, dv_den_reg};
    assign sq_rb  = sq_r_reg + sq_bit_reg;

    assign a_sel   = ch_reg ? a_r_reg : a_l_reg;
    assign b_sel   = ch_reg ? b_r_reg : b_l_reg;
    assign diff    = (SB+1)'(b_sel) - (SB+1)'(a_sel);
    assign v_val   = $signed((SB+2)'(a_sel)) + $signed((SB+2)'(prod_reg >>> 16));
    assign rnd     = prod_reg + ROUND_C;
    assign shr     = rnd >>> 28;
    assign sat_val = (shr > SAT_HI) ? SAT_HI[SB-1:0] :
                     (shr < SAT_LO) ? SAT_LO[SB-1:0] : shr[SB-1:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_FMUL:  begin mul_a = MW'(f_reg);    mul_b = MW'(fac_reg);        end
            ST_GMUL:  begin mul_a = MW'(gain_reg); mul_b = MW'(f_reg);          end
            ST_SDIF:  begin mul_a = MW'(diff);     mul_b = MW'(pos_reg[15:0]);  end
            ST_SOUT:  begin mul_a = MW'(v_reg);    mul_b = MW'(gf_reg);         end
            ST_SKMUL: begin mul_a = MW'(skip_cnt); mul_b = MW'(r_eff);          end
            default:  begin mul_a = '0;            mul_b = '0;                  end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (acc && !done_reg) begin
                state_next = (fi_reg != 40'd0 || s_tlast) ? ST_CHECK : ST_END;
            end
            ST_CHECK: priority if (run_ok) begin
                state_next = ST_FSEL;
            end else if (more) begin
                state_next = ST_DIV;
            end else if (!span_b_reg && cur_last_reg) begin
                state_next = ST_CHECK;
            end else begin
                state_next = ST_END;
            end
            ST_FSEL: priority if (fade_act) begin
                state_next = ST_DIV;
            end else if (k_reg == 2'd3) begin
                state_next = ST_GMUL;
            end else begin
                state_next = ST_FSEL;
            end
            ST_DIV: if (it_zero) begin
                state_next = dv_skip_reg ? ST_SKMUL : (k_reg[1] ? ST_SQRT : ST_FMUL);
            end
            ST_SQRT: if (it_zero) begin
                state_next = ST_FMUL;
            end
            ST_FMUL:  state_next = ST_FWB;
            ST_FWB:   state_next = (k_reg == 2'd3) ? ST_GMUL : ST_FSEL;
            ST_GMUL:  state_next = ST_GWB;
            ST_GWB:   state_next = ST_SDIF;
            ST_SDIF:  state_next = ST_SVAL;
            ST_SVAL:  state_next = ST_SOUT;
            ST_SOUT:  state_next = ST_SSAT;
            ST_SSAT:  state_next = ch_reg ? ST_EMIT : ST_SDIF;
            ST_EMIT:  if (emit_go) begin
                state_next = ST_CHECK;
            end
            ST_SKMUL: state_next = ST_SKADD;
            ST_SKADD: state_next = ST_CHECK;
            ST_END:   if (end_go) begin
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        acc      = s_tvalid && s_tready;
        out_free = !m_valid_reg || m_tready;
        emit_go  = (state_reg == ST_EMIT) && (!pend_valid_reg || out_free);
        end_go   = (state_reg == ST_END) && (!pend_valid_reg || out_free);
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = ODW'({m_pos_reg, m_r_reg, m_l_reg});

    // control and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rr_reg         <= 21'd65536;
            clen_reg       <= '0;
            gain_reg       <= 16'd16384;
            fin_reg        <= '0;
            fout_reg       <= '0;
            xin_reg        <= '0;
            xout_reg       <= '0;
            pos_reg        <= '0;
            cc_reg         <= '0;
            fi_reg         <= '0;
            prev_l_reg     <= '0;
            prev_r_reg     <= '0;
            done_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((emit_go || end_go) && pend_valid_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_addr))
                    REG_RATE_RATIO:   rr_reg   <= cfg_wdata[20:0];
                    REG_START_OFFSET: begin
                        pos_reg    <= cfg_wdata[55:0];
                        cc_reg     <= '0;
                        fi_reg     <= '0;
                        prev_l_reg <= '0;
                        prev_r_reg <= '0;
                        done_reg   <= 1'b0;
                    end
                    REG_CLIP_LENGTH:  clen_reg <= cfg_wdata[31:0];
                    REG_GAIN:         gain_reg <= cfg_wdata[15:0];
                    REG_FADE_IN:      fin_reg  <= cfg_wdata[31:0];
                    REG_FADE_OUT:     fout_reg <= cfg_wdata[31:0];
                    REG_XFADE_IN:     xin_reg  <= cfg_wdata[31:0];
                    REG_XFADE_OUT:    xout_reg <= cfg_wdata[31:0];
                    default: ;
                endcase
            end
            if (emit_go) begin
                cc_reg         <= cc_reg + 32'd1;
                pos_reg        <= pos_inc[56] ? '1 : pos_inc[55:0];
                pend_valid_reg <= 1'b1;
            end
            if (state_reg == ST_SKMUL) begin
                cc_reg <= cc_reg + skip_cnt;
            end
            if (state_reg == ST_SKADD) begin
                pos_reg <= pos_skip[56] ? '1 : pos_skip[55:0];
            end
            if (end_go) begin
                prev_l_reg <= cur_l_reg;
                prev_r_reg <= cur_r_reg;
                if (fi_reg != '1) begin
                    fi_reg <= fi_reg + 40'd1;
                end
                if (cur_last_reg) begin
                    done_reg <= 1'b1;
                end
                if (pend_valid_reg) begin
                    pend_valid_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg <= PW'(mul_a) * PW'(mul_b);
        unique case (state_reg)
            ST_IDLE: if (acc) begin
                cur_l_reg    <= s_tdata[SB-1:0];
                cur_r_reg    <= s_tdata[2*SB-1:SB];
                cur_last_reg <= s_tlast;
                n_reg        <= '0;
                if (fi_reg != 40'd0) begin
                    a_l_reg    <= prev_l_reg;
                    a_r_reg    <= prev_r_reg;
                    b_l_reg    <= s_tdata[SB-1:0];
                    b_r_reg    <= s_tdata[2*SB-1:SB];
                    bound_reg  <= bound_a;
                    span_b_reg <= 1'b0;
                end else begin
                    a_l_reg    <= s_tdata[SB-1:0];
                    a_r_reg    <= s_tdata[2*SB-1:SB];
                    b_l_reg    <= '0;
                    b_r_reg    <= '0;
                    bound_reg  <= bound_b;
                    span_b_reg <= 1'b1;
                end
            end
            ST_CHECK: priority if (run_ok) begin
                f_reg <= 25'h1000000;
                k_reg <= 2'd0;
            end else if (more) begin
                dv_rem_reg  <= '0;
                dv_den_reg  <= {11'b0, r_eff};
                dv_num_reg  <= skip_d;
                dv_q_reg    <= '0;
                dv_skip_reg <= 1'b1;
                it_reg      <= 6'd57;
            end else if (!span_b_reg && cur_last_reg) begin
                a_l_reg    <= cur_l_reg;
                a_r_reg    <= cur_r_reg;
                b_l_reg    <= '0;
                b_r_reg    <= '0;
                bound_reg  <= bound_b;
                span_b_reg <= 1'b1;
            end else begin
                span_b_reg <= span_b_reg;
            end
            ST_FSEL: if (fade_act) begin
                dv_rem_reg  <= fade_num;
                dv_den_reg  <= fade_len;
                dv_num_reg  <= '0;
                dv_q_reg    <= '0;
                dv_skip_reg <= 1'b0;
                it_reg      <= 6'd24;
            end else if (k_reg != 2'd3) begin
                k_reg <= k_reg + 2'd1;
            end
            ST_DIV: if (!it_zero) begin
                dv_rem_reg <= dv_ge ? dv_sub[31:0] : dv_t[31:0];
                dv_num_reg <= {dv_num_reg[55:0], 1'b0};
                dv_q_reg   <= {dv_q_reg[55:0], dv_ge};
                it_reg     <= it_reg - 6'd1;
            end else if (k_reg[1]) begin
                sq_x_reg   <= {dv_q_reg[23:0], 24'b0};
                sq_r_reg   <= '0;
                sq_bit_reg <= 48'h4000_0000_0000;
                it_reg     <= 6'd24;
            end else begin
                fac_reg <= dv_q_reg[23:0];
            end
            ST_SQRT: if (!it_zero) begin
                if (sq_x_reg >= sq_rb) begin
                    sq_x_reg <= sq_x_reg - sq_rb;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                it_reg     <= it_reg - 6'd1;
            end else begin
                fac_reg <= sq_r_reg[23:0];
            end
            ST_FWB: begin
                f_reg <= prod_reg[48:24];
                if (k_reg != 2'd3) begin
                    k_reg <= k_reg + 2'd1;
                end
            end
            ST_GWB: begin
                gf_reg <= prod_reg[39:10];
                ch_reg <= 1'b0;
            end
            ST_SVAL: v_reg <= v_val;
            ST_SSAT: begin
                if (ch_reg) begin
                    res_r_reg <= sat_val;
                end else begin
                    res_l_reg <= sat_val;
                end
                ch_reg <= 1'b1;
            end
            ST_EMIT: if (emit_go) begin
                if (pend_valid_reg) begin
                    m_l_reg    <= pend_l_reg;
                    m_r_reg    <= pend_r_reg;
                    m_pos_reg  <= pend_pos_reg;
                    m_last_reg <= 1'b0;
                end
                pend_l_reg   <= res_l_reg;
                pend_r_reg   <= res_r_reg;
                pend_pos_reg <= cc_reg;
                n_reg        <= n_reg + NW'(1);
            end
            ST_END: if (end_go && pend_valid_reg) begin
                m_l_reg    <= pend_l_reg;
                m_r_reg    <= pend_r_reg;
                m_pos_reg  <= pend_pos_reg;
                m_last_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending result left over at idle");

    a_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (n_reg <= NW'(MAX_OUTPUTS_PER_FRAME)))
        else $error("output count beyond cap");

    a_finished_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && done_reg) |=> (state_reg == ST_IDLE))
        else $error("item processed after finish");

    a_emit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_go && pend_valid_reg) |-> out_free)
        else $error("output register overwritten");

endmodule
